### design/pdm_pkg.sv
// ----------------------------------------------------------------------------
// Page dedup merge table package
// Shared types, register indexes and entry remap helper.
// ----------------------------------------------------------------------------
package pdm_pkg;

   localparam int PageW  = 44;
   localparam int AddrW  = 56;
   localparam int HashW  = 64;
   localparam int PteW   = 64;
   localparam int CountW = 5;
   localparam int ReqW   = 184;
   localparam int RspW   = 184;
   localparam int CsrIdxW = 8;

   localparam logic [CountW-1:0] COUNT_LIMIT = 5'd16;

   localparam logic [CsrIdxW-1:0] REG_ZERO_PAGE_ADDR = 8'd0;
   localparam logic [CsrIdxW-1:0] REG_ZERO_PAGE_HASH = 8'd1;

   localparam int WRITE_BIT = 2;
   localparam int MARK_BIT  = 8;

   typedef struct packed {
      logic              shared;
      logic [AddrW-1:0]  holder;
      logic [HashW-1:0]  hash;
      logic [PageW-1:0]  page;
      logic [CountW-1:0] count;
   } row_type;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_CLEAN = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   // read-only remap: new page number, write bit cleared, bit 8 marks COW
   function automatic logic [PteW-1:0] remap_entry(input logic [PteW-1:0] old_entry,
                                                   input logic [PageW-1:0] page_num);
      logic [PteW-1:0] e;
      e = {10'd0, page_num, old_entry[9:0]};
      e[WRITE_BIT] = 1'b0;
      e[MARK_BIT]  = old_entry[MARK_BIT] | old_entry[WRITE_BIT];
      return e;
   endfunction

endpackage

### design/page_dedup_merge_table_unit.sv
// ----------------------------------------------------------------------------
// Page dedup merge table
// Same-page merging table walked through one synchronous entry memory.
// ----------------------------------------------------------------------------
// Scan item: one pass over all entries from transfer to result; zero-page and
// zero-hash items go straight to the result without a pass. Cleanup likewise
// walks all entries in one pass. The pass is bounded by the single read port
// of the entry memory, one entry per cycle. One item in flight at a time.
// After reset a clearing pass empties the memory;
// no item is taken during it, config writes are.
module page_dedup_merge_table_unit #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // pte_value[63:0], pte_addr[119:64], page_hash[183:120]
   input  logic [pdm_pkg::ReqW-1:0]           req_tdata,
   // func
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // merged[0], entry_rewrite[1], new_entry[65:2], free_valid[66],
   // free_page[122:67], mark_valid[123], mark_addr[179:124], zero pad
   output logic [pdm_pkg::RspW-1:0]           rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pdm_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [63:0]                        csr_data
);

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CW-1:0] LAST_IDX = CW'(TABLE_ENTRIES - 1);
   localparam logic [CW-1:0] N_IDX    = CW'(TABLE_ENTRIES);

   pdm_pkg::row_type mem [TABLE_ENTRIES];

   pdm_pkg::state_type state_ff, state_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           rvld_ff, rvld_in;
   logic [AW-1:0]  ridx_ff, ridx_in;
   pdm_pkg::row_type rdata_ff;
   logic           func_ff, func_in, skip_ff, skip_in, zh_ff, zh_in;
   logic [63:0]    pte_ff, pte_in;
   logic [55:0]    eaddr_ff, eaddr_in;
   logic [63:0]    hash_ff, hash_in;
   logic           dup_ff, dup_in, cand_ff, cand_in, free_ff, free_in;
   logic [AW-1:0]  fidx_ff, fidx_in, cidx_ff, cidx_in;
   pdm_pkg::row_type crow_ff, crow_in;
   logic [55:0]    zpa_ff;
   logic [63:0]    zph_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [pdm_pkg::RspW-1:0] rsp_data_ff, rsp_data_in;

   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   pdm_pkg::row_type mem_wdata;
   logic             rd_en;

   logic [43:0] in_pn;
   logic [43:0] pn;
   logic        do_merge, do_rec, do_mark, rewrite;
   logic [63:0] new_entry;
   pdm_pkg::row_type merge_row, rec_row;

   assign req_tready = (state_ff == pdm_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign in_pn = req_tdata[53:10];
   assign pn    = pte_ff[53:10];
   assign rd_en = ((state_ff == pdm_pkg::ST_SCAN) || (state_ff == pdm_pkg::ST_CLEAN))
                  && (cnt_ff < N_IDX);

   // result decision after the pass
   assign do_merge = !func_ff && !skip_ff && !zh_ff && !dup_ff && cand_ff;
   assign do_rec   = !func_ff && !skip_ff && !zh_ff && !dup_ff && !cand_ff && free_ff;
   assign do_mark  = do_merge && (crow_ff.count == 5'd1) && (crow_ff.holder != 56'd0);
   assign rewrite  = do_merge || (!func_ff && !skip_ff && zh_ff);
   assign new_entry = pdm_pkg::remap_entry(pte_ff, zh_ff ? zpa_ff[55:12] : crow_ff.page);

   always_comb begin
      merge_row        = crow_ff;
      merge_row.count  = crow_ff.count + 5'd1;
      merge_row.shared = crow_ff.shared | do_mark;
      rec_row.shared   = 1'b0;
      rec_row.holder   = eaddr_ff;
      rec_row.hash     = hash_ff;
      rec_row.page     = pn;
      rec_row.count    = 5'd1;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rvld_in      = rd_en;
      ridx_in      = cnt_ff[AW-1:0];
      func_in      = func_ff;
      skip_in      = skip_ff;
      zh_in        = zh_ff;
      pte_in       = pte_ff;
      eaddr_in     = eaddr_ff;
      hash_in      = hash_ff;
      dup_in       = dup_ff;
      cand_in      = cand_ff;
      free_in      = free_ff;
      fidx_in      = fidx_ff;
      cidx_in      = cidx_ff;
      crow_in      = crow_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = cnt_ff[AW-1:0];
      mem_wdata    = '0;

      case (state_ff)
         pdm_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               state_in = pdm_pkg::ST_IDLE;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         pdm_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               func_in  = req_tuser;
               pte_in   = req_tdata[63:0];
               eaddr_in = req_tdata[119:64];
               hash_in  = req_tdata[183:120];
               skip_in  = 1'b0;
               zh_in    = 1'b0;
               dup_in   = 1'b0;
               cand_in  = 1'b0;
               free_in  = 1'b0;
               cnt_in   = '0;
               if (req_tuser) begin
                  state_in = pdm_pkg::ST_CLEAN;
               end else if ({in_pn, 12'd0} == zpa_ff) begin
                  skip_in  = 1'b1;
                  state_in = pdm_pkg::ST_DONE;
               end else if (req_tdata[183:120] == zph_ff) begin
                  zh_in    = 1'b1;
                  state_in = pdm_pkg::ST_DONE;
               end else begin
                  state_in = pdm_pkg::ST_SCAN;
               end
            end
         end
         pdm_pkg::ST_SCAN: begin
            if (rd_en) cnt_in = cnt_ff + CW'(1);
            if (rvld_ff) begin
               if (rdata_ff.count != 5'd0 && rdata_ff.page == pn) dup_in = 1'b1;
               if (!cand_ff && rdata_ff.count != 5'd0 && rdata_ff.count < pdm_pkg::COUNT_LIMIT
                   && rdata_ff.hash == hash_ff && rdata_ff.page != pn) begin
                  cand_in = 1'b1;
                  cidx_in = ridx_ff;
                  crow_in = rdata_ff;
               end
               if (!free_ff && rdata_ff.count == 5'd0) begin
                  free_in = 1'b1;
                  fidx_in = ridx_ff;
               end
            end
            if (cnt_ff == N_IDX && !rvld_ff) state_in = pdm_pkg::ST_DONE;
         end
         pdm_pkg::ST_CLEAN: begin
            if (rd_en) cnt_in = cnt_ff + CW'(1);
            // a count-1 entry that is not shared is cleared in the cycle after its read; no overlap
            if (rvld_ff && rdata_ff.count == 5'd1 && !rdata_ff.shared) begin
               mem_we    = 1'b1;
               mem_waddr = ridx_ff;
            end
            if (cnt_ff == N_IDX && !rvld_ff) state_in = pdm_pkg::ST_DONE;
         end
         pdm_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'd0,
                               do_mark ? crow_ff.holder : 56'd0, do_mark,
                               rewrite ? {pn, 12'd0} : 56'd0, rewrite,
                               rewrite ? new_entry : 64'd0, rewrite, rewrite};
               if (do_merge) begin
                  mem_we    = 1'b1;
                  mem_waddr = cidx_ff;
                  mem_wdata = merge_row;
               end else if (do_rec) begin
                  mem_we    = 1'b1;
                  mem_waddr = fidx_ff;
                  mem_wdata = rec_row;
               end
               state_in = pdm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pdm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rdata_ff <= mem[cnt_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pdm_pkg::ST_CLEAR;
         cnt_ff       <= '0;
         rvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         zpa_ff       <= '0;
         zph_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rvld_ff      <= rvld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_index == pdm_pkg::REG_ZERO_PAGE_ADDR) zpa_ff <= csr_data[55:0];
         if (csr_valid && csr_index == pdm_pkg::REG_ZERO_PAGE_HASH) zph_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      ridx_ff     <= ridx_in;
      func_ff     <= func_in;
      skip_ff     <= skip_in;
      zh_ff       <= zh_in;
      pte_ff      <= pte_in;
      eaddr_ff    <= eaddr_in;
      hash_ff     <= hash_in;
      dup_ff      <= dup_in;
      cand_ff     <= cand_in;
      free_ff     <= free_in;
      fidx_ff     <= fidx_in;
      cidx_ff     <= cidx_in;
      crow_ff     <= crow_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_no_take_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == pdm_pkg::ST_CLEAR |-> !req_tready)
      else $error("item taken during clearing pass");

   a_mark_needs_merge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[123] |-> rsp_data_ff[0] && rsp_data_ff[66])
      else $error("mark without merge");

   a_cleanup_walks: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> state_ff == pdm_pkg::ST_CLEAN)
      else $error("cleanup item did not start walk");

endmodule

### test/page_dedup_merge_table_unit_tb.sv
// ----------------------------------------------------------------------------
// Page dedup merge table testbench
// A directed table and then random scan/cleanup traffic over several register
// settings and idle patterns. Each result transfer is checked against an
// in-bench model of the merge table, or against a hand-written outcome.
// ----------------------------------------------------------------------------
module page_dedup_merge_table_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Entries = 64;
   localparam logic [pdm_pkg::CsrIdxW-1:0] REG_UNUSED = 8'hFF;
   localparam logic FUNC_SCAN = 1'b0;
   localparam logic FUNC_CLEANUP = 1'b1;

   typedef struct {
      logic                      merged;
      logic                      rewrite;
      logic [pdm_pkg::PteW-1:0]  new_entry;
      logic                      free_valid;
      logic [pdm_pkg::AddrW-1:0] free_page;
      logic                      mark_valid;
      logic [pdm_pkg::AddrW-1:0] mark_addr;
   } outcome_type;

   typedef struct {
      logic                      func;
      logic [pdm_pkg::PteW-1:0]  pte;
      logic [pdm_pkg::AddrW-1:0] paddr;
      logic [pdm_pkg::HashW-1:0] hash;
      bit                        typed;
      outcome_type               want;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [pdm_pkg::ReqW-1:0] req_tdata = '0;
   logic req_tuser = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [pdm_pkg::RspW-1:0] rsp_tdata;
   logic csr_valid = 0;
   logic csr_ready;
   logic [pdm_pkg::CsrIdxW-1:0] csr_index = '0;
   logic [63:0] csr_data = '0;

   page_dedup_merge_table_unit #(.TABLE_ENTRIES(Entries)) DUT (.*);

   always #6 clock = ~clock;

   // model state
   logic [pdm_pkg::AddrW-1:0] m_zpa;
   logic [pdm_pkg::HashW-1:0] m_zph;
   logic [pdm_pkg::CountW-1:0] m_count [Entries];
   logic [pdm_pkg::PageW-1:0] m_page [Entries];
   logic [pdm_pkg::HashW-1:0] m_hash [Entries];
   logic [pdm_pkg::AddrW-1:0] m_holder [Entries];
   logic m_shared [Entries];

   outcome_type pending_results[$];
   int failures = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_cycles = 0;
   int hold_request = 0;
   int hold_seen = 0;

   logic [pdm_pkg::PageW-1:0] page_pool [80];
   logic [pdm_pkg::HashW-1:0] hash_pool [8];

   function automatic logic [pdm_pkg::PteW-1:0] ro_entry(logic [pdm_pkg::PteW-1:0] old,
                                                          logic [pdm_pkg::PageW-1:0] pn);
      logic [pdm_pkg::PteW-1:0] e;
      e = {10'd0, pn, old[9:0] & ~10'h004};
      if (old[2]) e[8] = 1'b1;
      return e;
   endfunction

   task automatic merge_table_step(input row_type r, output outcome_type o);
      logic [pdm_pkg::PageW-1:0] pn;
      logic [pdm_pkg::AddrW-1:0] pa;
      bit done;
      pn = r.pte[53:10];
      pa = {pn, 12'd0};
      o = '{default: '0};
      done = 0;
      if (r.func == FUNC_CLEANUP) begin
         for (int i = 0; i < Entries; i++)
            if (m_count[i] == 5'd1 && !m_shared[i]) begin
               m_count[i] = '0;
               m_page[i] = '0;
               m_hash[i] = '0;
               m_holder[i] = '0;
               m_shared[i] = 1'b0;
            end
         return;
      end
      if (pa == m_zpa) return;
      if (r.hash == m_zph) begin
         o.merged = 1;
         o.rewrite = 1;
         o.new_entry = ro_entry(r.pte, m_zpa[pdm_pkg::AddrW-1:12]);
         o.free_valid = 1;
         o.free_page = pa;
         return;
      end
      for (int i = 0; i < Entries; i++)
         if (m_count[i] != 0 && m_page[i] == pn) return;
      for (int i = 0; i < Entries && !done; i++)
         if (m_count[i] != 0 && m_count[i] < pdm_pkg::COUNT_LIMIT && m_hash[i] == r.hash &&
             m_page[i] != pn) begin
            if (m_count[i] == 5'd1 && m_holder[i] != 0) begin
               o.mark_valid = 1;
               o.mark_addr = m_holder[i];
               m_shared[i] = 1'b1;
            end
            o.merged = 1;
            o.rewrite = 1;
            o.new_entry = ro_entry(r.pte, m_page[i]);
            o.free_valid = 1;
            o.free_page = pa;
            m_count[i] = m_count[i] + 5'd1;
            done = 1;
         end
      if (done) return;
      for (int i = 0; i < Entries; i++)
         if (m_count[i] == 0) begin
            m_holder[i] = r.paddr;
            m_page[i] = pn;
            m_hash[i] = r.hash;
            m_count[i] = 5'd1;
            m_shared[i] = 1'b0;
            break;
         end
   endtask

   task automatic write_reg(input logic [pdm_pkg::CsrIdxW-1:0] idx, input logic [63:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      if (idx == pdm_pkg::REG_ZERO_PAGE_ADDR) m_zpa = val[pdm_pkg::AddrW-1:0];
      else if (idx == pdm_pkg::REG_ZERO_PAGE_HASH) m_zph = val;
   endtask

   task automatic send_item(input row_type r);
      outcome_type o;
      req_tvalid <= 1;
      req_tuser <= r.func;
      req_tdata <= {r.hash, r.paddr, r.pte};
      do @(posedge clock); while (!req_tready);
      merge_table_step(r, o);
      pending_results.push_back(r.typed ? r.want : o);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (Entries + 8) @(posedge clock);
   endtask

   function automatic row_type random_row();
      row_type r;
      logic [pdm_pkg::PageW-1:0] pn;
      r.typed = 0;
      r.want = '{default: '0};
      r.func = ($urandom_range(999) < 15) ? FUNC_CLEANUP : FUNC_SCAN;
      pn = ($urandom_range(99) < 30) ? 44'({$urandom, $urandom}) :
                                       page_pool[$urandom_range(79)];
      r.pte = {10'($urandom_range(1023)), pn, 10'($urandom)};
      r.paddr = ($urandom_range(9) == 0) ? '0 : 56'({$urandom, $urandom});
      case ($urandom_range(19))
         0: r.hash = m_zph;
         1, 2, 3, 4: r.hash = {$urandom, $urandom};
         default: r.hash = hash_pool[$urandom_range(7)];
      endcase
      return r;
   endfunction

   // result checker
   always @(posedge clock) begin
      outcome_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result transfer");
            failures++;
         end else begin
            w = pending_results.pop_front();
            if (rsp_tdata[0] !== w.merged) begin
               $error("merged exp %h got %h", w.merged, rsp_tdata[0]); failures++;
            end
            if (rsp_tdata[1] !== w.rewrite) begin
               $error("entry_rewrite exp %h got %h", w.rewrite, rsp_tdata[1]); failures++;
            end
            if (rsp_tdata[65:2] !== w.new_entry) begin
               $error("new_entry exp %h got %h", w.new_entry, rsp_tdata[65:2]); failures++;
            end
            if (rsp_tdata[66] !== w.free_valid) begin
               $error("free_valid exp %h got %h", w.free_valid, rsp_tdata[66]); failures++;
            end
            if (rsp_tdata[122:67] !== w.free_page) begin
               $error("free_page exp %h got %h", w.free_page, rsp_tdata[122:67]); failures++;
            end
            if (rsp_tdata[123] !== w.mark_valid) begin
               $error("mark_valid exp %h got %h", w.mark_valid, rsp_tdata[123]); failures++;
            end
            if (rsp_tdata[179:124] !== w.mark_addr) begin
               $error("mark_addr exp %h got %h", w.mark_addr, rsp_tdata[179:124]);
               failures++;
            end
         end
      end
   end

   // receiver: random stalls, or a long hold-off when requested
   always @(posedge clock) begin
      if (hold_request != hold_seen) begin
         hold_seen <= hold_request;
         hold_cycles <= 400;
         rsp_tready <= 0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      row_type dir[$];
      row_type r;
      logic [pdm_pkg::HashW-1:0] h1, h2;

      for (int i = 0; i < Entries; i++) begin
         m_count[i] = '0; m_page[i] = '0; m_hash[i] = '0; m_holder[i] = '0;
         m_shared[i] = 1'b0;
      end
      m_zpa = '0;
      m_zph = '0;
      page_pool[0] = '0;
      page_pool[1] = '1;
      for (int i = 2; i < 80; i++) page_pool[i] = 44'({$urandom, $urandom});
      for (int i = 0; i < 8; i++) hash_pool[i] = {$urandom, $urandom};
      h1 = hash_pool[0];
      h2 = hash_pool[1];

      repeat (4) @(posedge clock);
      reset <= 0;

      // directed table, registers at reset values
      r = '{default: '0};
      r.func = FUNC_CLEANUP; r.typed = 1; dir.push_back(r);
      r = '{default: '0};
      r.pte = 64'h3FF; r.hash = h1; r.paddr = '1; r.typed = 1; dir.push_back(r);
      // zero-content page goes to zero page
      r = '{default: '0};
      r.pte = {10'd0, 44'd5, 10'h3FF}; r.hash = '0; r.typed = 1;
      r.want = '{1, 1, 64'h3FB, 1, 56'h5000, 0, '0};
      dir.push_back(r);
      r = '{default: '0};
      r.pte = {10'd0, 44'd7, 10'h004}; r.paddr = 56'h1000; r.hash = h1; dir.push_back(r);
      dir.push_back(r);   // same page again
      for (int p = 8; p < 24; p++) begin
         r.pte = {10'h3FF, 44'(p), 10'(p * 37)};
         r.paddr = 56'(p * 8);
         dir.push_back(r);  // fills the shared slot up to its limit; the last one takes a new slot
      end
      r.pte = {10'd0, 44'd100, 10'h0}; r.paddr = '0; r.hash = h2; dir.push_back(r);
      r.pte = {10'd0, 44'd101, 10'h104}; r.paddr = 56'h40; dir.push_back(r);
      r = '{default: '0};
      r.func = FUNC_CLEANUP; r.typed = 1; dir.push_back(r);
      r = '{default: '0};
      r.pte = '1; r.paddr = '1; r.hash = '1; dir.push_back(r);

      foreach (dir[i]) send_item(dir[i]);
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin
               write_reg(pdm_pkg::REG_ZERO_PAGE_ADDR, '1);
               write_reg(pdm_pkg::REG_ZERO_PAGE_HASH, '1);
               send_idle_pct = 51; recv_stall_pct = 0;
            end
            1: begin
               write_reg(pdm_pkg::REG_ZERO_PAGE_ADDR,
                         {8'hA5, page_pool[2 + $urandom_range(77)], 12'd0});
               write_reg(pdm_pkg::REG_ZERO_PAGE_HASH, {$urandom, $urandom});
               write_reg(REG_UNUSED, {$urandom, $urandom});
               send_idle_pct = 0; recv_stall_pct = 51;
            end
            2: begin
               write_reg(pdm_pkg::REG_ZERO_PAGE_ADDR, {8'h00, page_pool[0], 12'd0});
               write_reg(pdm_pkg::REG_ZERO_PAGE_HASH, hash_pool[7]);
               send_idle_pct = 9; recv_stall_pct = 9;
            end
            3: begin
               write_reg(pdm_pkg::REG_ZERO_PAGE_ADDR, {8'h00, page_pool[1], 12'h123});
               write_reg(pdm_pkg::REG_ZERO_PAGE_HASH, '0);
               send_idle_pct = 0; recv_stall_pct = 0;
            end
            default: begin
               write_reg(pdm_pkg::REG_ZERO_PAGE_ADDR,
                         {8'h00, page_pool[3 + $urandom_range(70)], 12'd0});
               write_reg(pdm_pkg::REG_ZERO_PAGE_HASH, {$urandom, $urandom});
               send_idle_pct = 9; recv_stall_pct = 51;
            end
         endcase
         for (int n = 0; n < 120; n++) begin
            if (ph == 3 && n == 40) hold_request++;  // block fills and stalls input
            if (ph == 4 && n == 60) drain();          // sender waits for all results
            send_item(random_row());
         end
         drain();
      end

      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
